// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Clocked on i_clk, masked during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/nic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nic_pkg
// Widths, FSM states and controller/datapath interface types for the
// threshold crossing interpolation unit.
// ----------------------------------------------------------------------------
package nic_pkg;

    localparam int VALUE_W   = 32;               // signed Q16.16
    localparam int GRAD_W    = 2;
    localparam int OCC_W     = 8;
    localparam int COUNT_W   = OCC_W;
    localparam int MAG_W     = VALUE_W + 1;      // magnitude of a difference
    localparam int STEP_W    = $clog2(MAG_W);

    localparam int IN_FIELDS_W = 3 * VALUE_W + GRAD_W + OCC_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VALUE_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;      // capture input beat
        logic eval;      // crossing test, count and previous-value update
        logic fin;       // write held result from divider
        logic emit;      // move held result to output register
    } t_dp_cmd;

    typedef struct packed {
        logic hit;       // this level reaches the wanted crossing
        logic last;      // captured level closes the column
        logic div_busy;
        logic out_free;  // output register can take a beat
    } t_dp_sts;

endpackage

// File: rtl/core/nic_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nic_muldiv
// Bit-serial round(a * b / d) for b < d: one bit of a per cycle, remainder
// kept below d, halves rounded up.
// ----------------------------------------------------------------------------
module nic_muldiv
    import nic_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_a,
    input  logic [MAG_W-1:0] i_b,
    input  logic [MAG_W-1:0] i_d,
    output logic             o_busy,
    output logic [MAG_W:0]   o_quot
);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [MAG_W-1:0]  r_a;
    logic [MAG_W-1:0]  r_b;
    logic [MAG_W-1:0]  r_d;
    logic [MAG_W-1:0]  r_r;
    logic [MAG_W:0]    r_q;

    logic [MAG_W-1:0]  n_r;
    logic [MAG_W:0]    n_q;
    logic [MAG_W+1:0]  sum;
    logic [MAG_W+1:0]  d1;
    logic [MAG_W+1:0]  d2;
    logic [1:0]        qd;
    logic              rnd;

    // 2r + b < 3d, so at most 2d comes off in one step
    always_comb begin
        sum = {1'b0, r_r, 1'b0} + (r_a[MAG_W-1] ? {2'b00, r_b} : '0);
        d1  = {2'b00, r_d};
        d2  = {1'b0, r_d, 1'b0};
        if (sum >= d2) begin
            n_r = MAG_W'(sum - d2);
            qd  = 2'd2;
        end else if (sum >= d1) begin
            n_r = MAG_W'(sum - d1);
            qd  = 2'd1;
        end else begin
            n_r = sum[MAG_W-1:0];
            qd  = 2'd0;
        end
        n_q = {r_q[MAG_W-1:0], 1'b0} + {{(MAG_W-1){1'b0}}, qd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(MAG_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_d <= i_d;
            r_r <= '0;
            r_q <= '0;
        end else if (r_busy) begin
            r_a <= {r_a[MAG_W-2:0], 1'b0};
            r_r <= n_r;
            r_q <= n_q;
        end
    end

    assign rnd    = {r_r, 1'b0} >= {1'b0, r_d};
    assign o_busy = r_busy;
    assign o_quot = r_q + {{MAG_W{1'b0}}, rnd};

endmodule

// File: rtl/core/nic_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nic_datapath
// Input capture, crossing test, crossing count, held result and output
// register; drives the serial multiply-divide for the interpolation.
// ----------------------------------------------------------------------------
module nic_datapath
    import nic_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic                      i_first_level,
    input  logic                      i_last_level,
    input  logic signed [VALUE_W-1:0] i_iso_value,
    input  logic signed [VALUE_W-1:0] i_field_value,
    input  logic signed [VALUE_W-1:0] i_threshold,
    input  logic signed [GRAD_W-1:0]  i_grad_sign,
    input  logic        [OCC_W-1:0]   i_occurrence,
    input  logic                      i_m_ready,
    output logic                      o_m_valid,
    output logic signed [VALUE_W-1:0] o_crossing_value,
    output logic                      o_found
);

    // captured beat
    logic                      r_first;
    logic                      r_last;
    logic signed [VALUE_W-1:0] r_iso;
    logic signed [VALUE_W-1:0] r_fld;
    logic signed [VALUE_W-1:0] r_thr;
    logic signed [GRAD_W-1:0]  r_grad;
    logic        [OCC_W-1:0]   r_occ;

    // column state
    logic signed [VALUE_W-1:0] r_prev_iso;
    logic signed [VALUE_W-1:0] r_prev_fld;
    logic        [COUNT_W-1:0] r_count;
    logic signed [VALUE_W-1:0] r_held;
    logic                      r_held_found;

    // interpolation operands
    logic signed [VALUE_W-1:0] r_base;
    logic                      r_neg;

    // output register
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic                      r_out_found;

    logic                      rising;
    logic                      falling;
    logic                      dir_ok;
    logic                      cnt_ok;
    logic                      step;
    logic        [COUNT_W-1:0] cnt_inc;
    logic                      hit;
    logic signed [MAG_W-1:0]   df;
    logic signed [MAG_W-1:0]   dt;
    logic signed [MAG_W-1:0]   di;
    logic        [MAG_W-1:0]   mag_df;
    logic        [MAG_W-1:0]   mag_dt;
    logic        [MAG_W-1:0]   mag_di;
    logic                      div_busy;
    logic        [MAG_W:0]     inc;
    logic signed [MAG_W:0]     base_x;
    logic        [MAG_W:0]     interp;

    always_comb begin
        rising  = (r_prev_iso <= r_thr) && (r_thr < r_iso);
        falling = (r_prev_iso >= r_thr) && (r_thr > r_iso);
        dir_ok  = (r_grad == '0) || (!r_grad[GRAD_W-1] && rising)
                  || (r_grad[GRAD_W-1] && falling);
        cnt_ok  = (r_count < r_occ) && (r_count != COUNT_MAX);
        step    = !r_first && (rising || falling) && dir_ok && cnt_ok;
        cnt_inc = r_count + 1'b1;
        hit     = step && (cnt_inc == r_occ);

        df = MAG_W'(r_fld) - MAG_W'(r_prev_fld);
        dt = MAG_W'(r_thr) - MAG_W'(r_prev_iso);
        di = MAG_W'(r_iso) - MAG_W'(r_prev_iso);
        mag_df = df[MAG_W-1] ? MAG_W'(-df) : df;
        mag_dt = dt[MAG_W-1] ? MAG_W'(-dt) : dt;
        mag_di = di[MAG_W-1] ? MAG_W'(-di) : di;

        base_x = {{2{r_base[VALUE_W-1]}}, r_base};
        interp = r_neg ? (base_x - inc) : (base_x + inc);
    end

    nic_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.eval && hit),
        .i_a     (mag_df),
        .i_b     (mag_dt),
        .i_d     (mag_di),
        .o_busy  (div_busy),
        .o_quot  (inc)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_first <= i_first_level;
            r_last  <= i_last_level;
            r_iso   <= i_iso_value;
            r_fld   <= i_field_value;
            r_thr   <= i_threshold;
            r_grad  <= i_grad_sign;
            r_occ   <= i_occurrence;
        end
        if (i_cmd.eval && hit) begin
            r_base <= r_prev_fld;
            r_neg  <= df[MAG_W-1];
        end
        if (i_cmd.emit) begin
            r_out_value <= r_held_found ? r_held : '0;
            r_out_found <= r_held_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_iso   <= '0;
            r_prev_fld   <= '0;
            r_count      <= '0;
            r_held       <= '0;
            r_held_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_prev_iso <= r_iso;
                r_prev_fld <= r_fld;
                if (r_first) begin
                    r_count      <= '0;
                    r_held       <= '0;
                    r_held_found <= 1'b0;
                end else if (step) begin
                    r_count <= cnt_inc;
                end
            end
            if (i_cmd.fin) begin
                r_held       <= interp[VALUE_W-1:0];
                r_held_found <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_count      <= '0;
                r_held       <= '0;
                r_held_found <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.hit      = hit;
        o_sts.last     = r_last;
        o_sts.div_busy = div_busy;
        o_sts.out_free = !r_out_valid || i_m_ready;
    end

    assign o_m_valid        = r_out_valid;
    assign o_crossing_value = r_out_value;
    assign o_found          = r_out_found;

endmodule

// File: rtl/core/nic_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nic_ctrl
// Sequencer: accept a level, evaluate it, wait out the interpolation when
// the wanted crossing is hit, and hand the column result to the output.
// ----------------------------------------------------------------------------
module nic_ctrl
    import nic_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
                if (i_s_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_DIV;
                end else if (i_sts.last) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = i_sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // wait for the output register to drain
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/nth_isosurface_crossing_interp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nth_isosurface_crossing_interp_unit
// Nth threshold crossing along a grid column with linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one level per beat in search order; tuser marks the first
//   level of a column, tlast the last. m_axis returns one beat per column
//   after its last level: interpolated value in tdata, found flag in tuser
//   (value is zero when not found).
//   An ordinary level is captured and then evaluated. The level that
//   reaches the wanted crossing also waits for the bit-serial
//   multiply-divide (one quotient bit per cycle over 33 magnitude bits) and
//   then writes back. A last level also loads the output register.
//   Reset clears previous values, count, held result and the output valid
//   flag. A finished result waits in the output register while the next
//   column streams in; if the receiver stalls and another result is due,
//   input is held off until the output register drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nth_isosurface_crossing_interp_unit
    import nic_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // iso_value, field_value, threshold, grad_sign, occurrence, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // first_level
    input  logic [0:0]             s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // crossing_value
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // found
    output logic [0:0]             m_axis_tuser
);

    localparam int FLD_LO = VALUE_W;
    localparam int THR_LO = 2 * VALUE_W;
    localparam int GRD_LO = 3 * VALUE_W;
    localparam int OCC_LO = GRD_LO + GRAD_W;

    t_dp_cmd                   cmd;
    t_dp_sts                   sts;
    logic signed [VALUE_W-1:0] crossing_value;
    logic                      found;

    nic_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    nic_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_first_level    (s_axis_tuser[0]),
        .i_last_level     (s_axis_tlast),
        .i_iso_value      (s_axis_tdata[VALUE_W-1:0]),
        .i_field_value    (s_axis_tdata[FLD_LO +: VALUE_W]),
        .i_threshold      (s_axis_tdata[THR_LO +: VALUE_W]),
        .i_grad_sign      (s_axis_tdata[GRD_LO +: GRAD_W]),
        .i_occurrence     (s_axis_tdata[OCC_LO +: OCC_W]),
        .i_m_ready        (m_axis_tready),
        .o_m_valid        (m_axis_tvalid),
        .o_crossing_value (crossing_value),
        .o_found          (found)
    );

    assign m_axis_tdata = OUT_TDATA_W'(unsigned'(crossing_value));
    assign m_axis_tuser = found;

    `ASSERT_NEXT(a_one_beat_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input accepted again while a level is in flight")
    `ASSERT_CLK(a_missing_is_zero, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0),
        "missing result carries a nonzero value")
    `ASSERT_NEXT(a_div_starts, cmd.eval && sts.hit, sts.div_busy,
        "interpolation divider did not start on a hit")

endmodule

// File: tb/sv/nth_isosurface_crossing_interp_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nth_isosurface_crossing_interp_unit_tb
// Self-checking bench for the nth threshold crossing interpolation unit.
// ----------------------------------------------------------------------------
// Levels go in on s_axis with random gaps. A behavioural column model
// predicts the interpolated value and found flag for every column close.
// Results on m_axis are checked in order against it, and m_axis_tready is
// throttled at random. One long sink stall fills the output and holds off
// input. The directed columns come first, then random columns.
// ----------------------------------------------------------------------------
module nth_isosurface_crossing_interp_unit_tb
    import nic_pkg::*;
();

    localparam int          CLK_HALF     = 6;
    localparam int          RESET_CYCLES = 8;
    localparam int          DRAIN_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          ONE          = 32'sh0001_0000;   // 1.0 in Q16.16

    // grad_sign patterns
    localparam logic [GRAD_W-1:0] GRAD_ANY       = 2'b00;
    localparam logic [GRAD_W-1:0] GRAD_RISE      = 2'b01;
    localparam logic [GRAD_W-1:0] GRAD_FALL_WIDE = 2'b10;    // -2, still falling
    localparam logic [GRAD_W-1:0] GRAD_FALL      = 2'b11;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               found;
    } t_crossing;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // iso_value, field_value, threshold, grad_sign, occurrence, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // first_level
    logic [0:0]             s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // crossing_value
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // found
    logic [0:0]             m_axis_tuser;

    // column model state
    longint             col_prev_iso;
    longint             col_prev_field;
    logic [COUNT_W-1:0] col_count;
    logic [VALUE_W-1:0] col_held_value;
    logic               col_held_found;

    t_crossing   crossings_due[$];
    int unsigned mismatches;
    int unsigned levels_sent;
    int unsigned cycle_count;
    int unsigned sink_hold_cycles;
    bit          src_idle_en;
    bit          snk_idle_en;

    nth_isosurface_crossing_interp_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Column model
    // ------------------------------------------------------------------------
    task automatic reset_column_model();
        col_prev_iso   = 0;
        col_prev_field = 0;
        col_count      = '0;
        col_held_value = '0;
        col_held_found = 1'b0;
    endtask

    task automatic predict_level(input bit first, input bit last, input int iso,
                                 input int fld, input int thr,
                                 input logic [GRAD_W-1:0] grad,
                                 input logic [OCC_W-1:0] occ);
        longint      c_iso, c_fld, t, df, dt, di;
        bit          rising, falling, dir_ok;
        logic [127:0] num, quo, rem;
        t_crossing   due;
        c_iso = longint'(iso);
        c_fld = longint'(fld);
        t     = longint'(thr);
        if (first) begin
            col_count      = '0;
            col_held_value = '0;
            col_held_found = 1'b0;
        end else begin
            rising  = (col_prev_iso <= t) && (t < c_iso);
            falling = (col_prev_iso >= t) && (t > c_iso);
            case (grad)
                GRAD_ANY:  dir_ok = 1'b1;
                GRAD_RISE: dir_ok = rising;
                default:   dir_ok = falling;
            endcase
            if ((rising || falling) && dir_ok && col_count < occ && col_count < COUNT_MAX) begin
                col_count++;
                if (col_count == occ) begin
                    df  = c_fld - col_prev_field;
                    dt  = (t - col_prev_iso) < 0 ? col_prev_iso - t : t - col_prev_iso;
                    di  = (c_iso - col_prev_iso) < 0 ? col_prev_iso - c_iso
                                                     : c_iso - col_prev_iso;
                    num = 128'(df < 0 ? -df : df) * 128'(dt);
                    quo = num / 128'(di);
                    rem = num % 128'(di);
                    // halves go away from zero
                    if ((rem << 1) >= 128'(di))
                        quo++;
                    col_held_value = VALUE_W'(df < 0 ? col_prev_field - longint'(quo)
                                                     : col_prev_field + longint'(quo));
                    col_held_found = 1'b1;
                end
            end
        end
        col_prev_iso   = c_iso;
        col_prev_field = c_fld;
        if (last) begin
            due.value = col_held_found ? col_held_value : '0;
            due.found = col_held_found;
            crossings_due.push_back(due);
            col_count      = '0;
            col_held_value = '0;
            col_held_found = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------
    task automatic offer_level(input bit first, input bit last, input int iso,
                               input int fld, input int thr,
                               input logic [GRAD_W-1:0] grad,
                               input logic [OCC_W-1:0] occ);
        int unsigned gap;
        gap = src_idle_en ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, occ, grad, thr, fld, iso};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_level(first, last, iso, fld, thr, grad, occ);
        levels_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Sink side: per-beat random stall, plus one long hold on request
    // ------------------------------------------------------------------------
    initial begin : sink
        int unsigned gap;
        m_axis_tready <= 1'b0;
        forever begin
            gap = snk_idle_en ? $urandom_range(0, 8) : 0;
            if (sink_hold_cycles > 0) begin
                gap              = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge i_clk) begin : result_check
        t_crossing due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (crossings_due.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got value %h found %b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                due = crossings_due.pop_front();
                if (m_axis_tdata[VALUE_W-1:0] !== due.value) begin
                    $display("%0t: crossing_value expected %h, got %h",
                             $time, due.value, m_axis_tdata[VALUE_W-1:0]);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== due.found) begin
                    $display("%0t: found expected %b, got %b",
                             $time, due.found, m_axis_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    function automatic int near(input int centre, input int unsigned spread);
        longint v;
        v = longint'(centre) + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
        if (v > 64'sh7FFF_FFFF)
            v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            v = -64'sh8000_0000;
        return int'(v);
    endfunction

    task automatic apply_reset();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reset_column_model();
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_one_level_columns();
        offer_level(1, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, GRAD_ANY, 8'hFF);
        offer_level(1, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, GRAD_RISE, 8'd1);
    endtask

    task automatic test_rising_and_rounding();
        // previous level sitting exactly on the threshold still counts as rising
        offer_level(1, 0, 0, 0, 0, GRAD_ANY, 8'd1);
        offer_level(0, 1, 3 * ONE, 10 * ONE, 0, GRAD_ANY, 8'd1);
        // half-way increments, positive and negative
        offer_level(1, 0, -1, 0, 0, GRAD_ANY, 8'd1);
        offer_level(0, 1, 1, 1, 0, GRAD_ANY, 8'd1);
        offer_level(1, 0, -1, 0, 0, GRAD_ANY, 8'd1);
        offer_level(0, 1, 1, -1, 0, GRAD_ANY, 8'd1);
    endtask

    task automatic test_direction_filter();
        // rise, fall, rise; only the fall qualifies
        offer_level(1, 0, -ONE, 1 * ONE, 0, GRAD_FALL, 8'd1);
        offer_level(0, 0, ONE, 5 * ONE, 0, GRAD_FALL, 8'd1);
        offer_level(0, 0, -ONE, -3 * ONE, 0, GRAD_FALL, 8'd1);
        offer_level(0, 1, ONE, 7 * ONE, 0, GRAD_FALL, 8'd1);
        // second rising crossing
        offer_level(1, 0, -ONE, 2 * ONE, ONE / 2, GRAD_RISE, 8'd2);
        offer_level(0, 0, ONE, 4 * ONE, ONE / 2, GRAD_RISE, 8'd2);
        offer_level(0, 0, -ONE, 6 * ONE, ONE / 2, GRAD_RISE, 8'd2);
        offer_level(0, 1, 2 * ONE, 9 * ONE, ONE / 2, GRAD_RISE, 8'd2);
        // the -2 pattern behaves as falling
        offer_level(1, 0, ONE, 0, 0, GRAD_FALL_WIDE, 8'd1);
        offer_level(0, 1, -3 * ONE, 8 * ONE, 0, GRAD_FALL_WIDE, 8'd1);
    endtask

    task automatic test_occurrence_zero();
        offer_level(1, 0, -ONE, 0, 0, GRAD_ANY, 8'd0);
        offer_level(0, 1, ONE, ONE, 0, GRAD_ANY, 8'd0);
    endtask

    task automatic test_later_crossings();
        // first crossing held, second one ignored
        offer_level(1, 0, -ONE, 0, 0, GRAD_ANY, 8'd1);
        offer_level(0, 0, ONE, 2 * ONE, 0, GRAD_ANY, 8'd1);
        offer_level(0, 1, -ONE, 100 * ONE, 0, GRAD_ANY, 8'd1);
        // no first mark: carries on from the previous level's values
        offer_level(0, 1, 4 * ONE, -6 * ONE, 0, GRAD_ANY, 8'd1);
    endtask

    task automatic test_extreme_span();
        offer_level(1, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, GRAD_ANY, 8'd1);
        offer_level(0, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFE, GRAD_RISE, 8'd1);
    endtask

    // count saturates at the top occurrence value
    task automatic test_count_limit();
        int n;
        offer_level(1, 0, -ONE, int'($urandom), 0, GRAD_ANY, 8'd255);
        for (n = 1; n <= 257; n++)
            offer_level(0, n == 257, (n % 2) ? ONE : -ONE, int'($urandom), 0, GRAD_ANY,
                        8'd255);
        offer_level(1, 0, -ONE, 0, 0, GRAD_RISE, 8'd255);
        for (n = 1; n <= 12; n++)
            offer_level(0, n == 12, (n % 2) ? ONE : -ONE, n * ONE, 0, GRAD_RISE, 8'd255);
    endtask

    // sink stalls long while one-level columns keep coming
    task automatic test_output_backpressure();
        int n;
        sink_hold_cycles = 300;
        for (n = 0; n < 24; n++)
            offer_level(1, 1, int'($urandom), int'($urandom), int'($urandom),
                        GRAD_ANY, 8'd1);
        offer_level(1, 0, -ONE, ONE, 0, GRAD_ANY, 8'd1);
        offer_level(0, 1, ONE, -ONE, 0, GRAD_ANY, 8'd1);
    endtask

    // ------------------------------------------------------------------------
    // Random columns, mostly built around the threshold so crossings happen
    // ------------------------------------------------------------------------
    task automatic test_random_columns(input int unsigned n_levels);
        int unsigned        stop_at, len, spread, k;
        logic [OCC_W-1:0]   occ;
        logic [GRAD_W-1:0]  grad;
        int                 thr_base, thr, iso, fld;
        bit                 wild, first;
        stop_at = levels_sent + n_levels;
        while (levels_sent < stop_at) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            case ($urandom_range(0, 9))
                0:       occ = OCC_W'($urandom);
                1, 2:    occ = OCC_W'($urandom_range(0, 8));
                default: occ = OCC_W'($urandom_range(1, 3));
            endcase
            grad = GRAD_W'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0:       thr_base = int'($urandom);
                1:       thr_base = 0;
                default: thr_base = near(0, 32 * ONE);
            endcase
            spread = 1 << $urandom_range(2, 30);
            wild   = ($urandom_range(0, 9) == 0);
            for (k = 0; k < len; k++) begin
                thr = ($urandom_range(0, 6) == 0) ? near(thr_base, spread) : thr_base;
                if (wild || $urandom_range(0, 12) == 0)
                    iso = int'($urandom);
                else if ($urandom_range(0, 9) == 0)
                    iso = thr;
                else
                    iso = near(thr, spread);
                fld = $urandom_range(0, 1) ? int'($urandom) : near(0, 64 * ONE);
                first = (k == 0) ? ($urandom_range(0, 14) != 0) : ($urandom_range(0, 40) == 0);
                offer_level(first, k == len - 1, iso, fld, thr, grad, occ);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        mismatches       = 0;
        levels_sent      = 0;
        cycle_count      = 0;
        sink_hold_cycles = 0;
        src_idle_en      = 1'b0;
        snk_idle_en      = 1'b0;
        apply_reset();

        test_one_level_columns();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        test_rising_and_rounding();
        test_direction_filter();
        test_occurrence_zero();
        test_later_crossings();
        test_extreme_span();
        test_count_limit();

        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        test_output_backpressure();

        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        test_random_columns(700);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        test_random_columns(300);
        snk_idle_en = 1'b1;
        test_random_columns(200);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b0;
        test_random_columns(150);

        s_axis_tvalid <= 1'b0;
        while (crossings_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && crossings_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
